FILE: hw/rtl/lpm_pkg.sv
package lpm_pkg;

	// Table sizing
	localparam int TABLE_DEPTH = 64;
	localparam int NUM_IFACES  = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 6;
	localparam int IFACE_W = 4;
	localparam int TTL_W   = 8;
	localparam int MAX_LEN = 32;

	typedef enum logic {
		MODE_ADD   = 1'b0,
		MODE_ROUTE = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_FORWARDED   = 3'd0,
		ST_NO_ROUTE    = 3'd1,
		ST_TTL_EXPIRED = 3'd2,
		ST_ADDED       = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	// Input beat
	typedef struct packed {
		mode_t              mode;
		logic [ADDR_W-1:0]  pfx_addr;
		logic [LEN_W-1:0]   pfx_len;
		logic               has_next_hop;
		logic [ADDR_W-1:0]  next_hop_addr;
		logic [IFACE_W-1:0] route_iface;
		logic [ADDR_W-1:0]  dst_addr;
		logic [TTL_W-1:0]   ttl_in;
	} req_t;

	// Result beat
	typedef struct packed {
		status_t            status;
		logic [IFACE_W-1:0] out_iface;
		logic [ADDR_W-1:0]  hop_addr;
		logic [TTL_W-1:0]   ttl_out;
	} rsp_t;

	// One stored route
	typedef struct packed {
		logic [ADDR_W-1:0]  prefix;
		logic [LEN_W-1:0]   len;
		logic               direct;
		logic [ADDR_W-1:0]  hop;
		logic [IFACE_W-1:0] iface;
	} entry_t;

	// Netmask for a prefix length (length already saturated to 32)
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= LEN_W'(MAX_LEN)) begin
			m = '1;
		end else begin
			m = {ADDR_W{1'b1}} << (LEN_W'(MAX_LEN) - len);
		end
		return m;
	endfunction

endpackage

FILE: hw/rtl/longest_prefix_match_router.sv
// IPv4 longest-prefix-match forwarding core.
// Input channel: a request beat (req) is taken on the rising edge where start is
// high and busy is low. req.mode selects add-route or route-a-datagram.
// Output channel: one result beat per request, shown on rsp for exactly one cycle
// with done high. The receiver cannot stall; rsp is valid only while done is high.
// Timing and rate: an add answers in the cycle after it is taken and busy stays
// low, so adds may follow one per cycle. A lookup reads the route RAM once per
// stored route, one entry per cycle through its single read port, and holds busy
// high until the cycle its result is shown, so no new request is taken meanwhile.
// Among equal prefix lengths the later route wins, because entries are scanned
// in insertion order and a tie replaces the running best.
// Reset: arst_n low empties the table (entry count to zero) and drops any lookup
// in progress; the RAM itself is not cleared, only entries below the count are
// ever read.
module longest_prefix_match_router_core
	import lpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [0:0] {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   dst_q;
	logic [TTL_W-1:0]    ttl_q;
	logic                found_q;
	logic [LEN_W-1:0]    best_len_q;
	logic                best_direct_q;
	logic [ADDR_W-1:0]   best_hop_q;
	logic [IFACE_W-1:0]  best_iface_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                add_ok;
	logic                ram_we;
	entry_t              wr_entry;
	entry_t              rd_entry;
	logic [LEN_W-1:0]    sat_len;
	logic                scan_more;
	logic                hit;
	logic                take;
	logic                finish;
	rsp_t                add_rsp;
	rsp_t                lookup_rsp;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign add_ok = (count_q != CNT_W'(TABLE_DEPTH));
	assign ram_we = accept && (req.mode == MODE_ADD) && add_ok;

	// New route: saturate length, flip next-hop flag into direct flag
	always_comb begin
		sat_len = (req.pfx_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.pfx_len;
		wr_entry.prefix = req.pfx_addr;
		wr_entry.len    = sat_len;
		wr_entry.direct = !req.has_next_hop;
		wr_entry.hop    = req.next_hop_addr;
		wr_entry.iface  = IFACE_W'(32'(req.route_iface) % NUM_IFACES);
	end

	// Route table; writes only while idle, read data is used only while scanning
	lpm_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(wr_entry),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(rd_entry)
	);

	// Compare the entry read last cycle against the destination
	always_comb begin
		scan_more = (scan_idx_q != count_q);
		hit       = (((dst_q ^ rd_entry.prefix) & len_mask(rd_entry.len)) == '0);
		take      = rd_vld_s1 && hit && (!found_q || (rd_entry.len >= best_len_q));
		finish    = (state_q == S_SCAN) && !scan_more && !rd_vld_s1;
	end

	// Result beats
	always_comb begin
		add_rsp           = '0;
		add_rsp.status    = add_ok ? ST_ADDED : ST_FULL;

		lookup_rsp        = '0;
		if (!found_q) begin
			lookup_rsp.status = ST_NO_ROUTE;
		end else if (ttl_q <= TTL_W'(1)) begin
			lookup_rsp.status = ST_TTL_EXPIRED;
		end else begin
			lookup_rsp.status    = ST_FORWARDED;
			lookup_rsp.out_iface = best_iface_q;
			lookup_rsp.hop_addr  = best_direct_q ? dst_q : best_hop_q;
			lookup_rsp.ttl_out   = ttl_q - TTL_W'(1);
		end
	end

	// Control, scan and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			scan_idx_q    <= '0;
			rd_vld_s1     <= 1'b0;
			dst_q         <= '0;
			ttl_q         <= '0;
			found_q       <= 1'b0;
			best_len_q    <= '0;
			best_direct_q <= 1'b0;
			best_hop_q    <= '0;
			best_iface_q  <= '0;
			done_q        <= 1'b0;
			rsp_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q    <= accept && (req.mode == MODE_ADD);
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						if (req.mode == MODE_ADD) begin
							rsp_q  <= add_rsp;
							if (add_ok) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							dst_q      <= req.dst_addr;
							ttl_q      <= req.ttl_in;
							found_q    <= 1'b0;
							best_len_q <= '0;
							scan_idx_q <= '0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= scan_more;
					done_q    <= finish;
					if (scan_more) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (take) begin
						found_q       <= 1'b1;
						best_len_q    <= rd_entry.len;
						best_direct_q <= rd_entry.direct;
						best_hop_q    <= rd_entry.hop;
						best_iface_q  <= rd_entry.iface;
					end
					if (finish) begin
						rsp_q   <= lookup_rsp;
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q    <= 1'b0;
					rd_vld_s1 <= 1'b0;
					state_q   <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hw/rtl/lpm_ram.sv
module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/lpm_chk.sv
module lpm_chk
	import lpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// An add beat is answered in the following cycle
	a_add_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.mode == MODE_ADD) |=> done &&
		(rsp.status == ST_ADDED || rsp.status == ST_FULL))
		else $error("add beat not answered in one cycle");

	// A lookup beat raises busy in the following cycle
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.mode == MODE_ROUTE) |=> busy && !done)
		else $error("lookup beat did not start a scan");

	// Result beats carry a defined status
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_FORWARDED || rsp.status == ST_NO_ROUTE ||
		rsp.status == ST_TTL_EXPIRED || rsp.status == ST_ADDED ||
		rsp.status == ST_FULL))
		else $error("undefined status code");

	// Only forwarded beats carry forwarding fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_FORWARDED) |->
		(rsp.out_iface == '0) && (rsp.hop_addr == '0) && (rsp.ttl_out == '0))
		else $error("dropped or add beat carries forwarding fields");

	// A forwarded datagram always leaves with a live TTL
	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_FORWARDED) |-> (rsp.ttl_out != '0))
		else $error("forwarded beat with zero TTL");

endmodule

bind longest_prefix_match_router_core lpm_chk u_lpm_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
